/* sv/assert_macros.svh */
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/fpa_pkg.sv */
// shared types and constants of the partition allocator
`default_nettype none
package fpa_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_NOFIT  = 3'd1;
  localparam status_t ST_NOPROC = 3'd2;
  localparam status_t ST_FULL   = 3'd3;
  localparam status_t ST_ZERO   = 3'd4;

  localparam logic [1:0] FN_ALLOC  = 2'd0;
  localparam logic [1:0] FN_FREE   = 2'd1;
  localparam logic [1:0] FN_INIT   = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic REG_IDX_BASE   = 1'b0;
  localparam logic REG_IDX_LENGTH = 1'b1;

  localparam logic [23:0] BASE_RESET   = 24'd11240;
  localparam logic [23:0] LENGTH_RESET = 24'd101400;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS1,
    S_PASS2,
    S_PASS3,
    S_DROP
  } fpa_state_t;

  typedef struct packed {
    logic clr;
    logic load;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* sv/fpa_cell.sv */
// one table entry of the allocator ring
`default_nettype none
module fpa_cell #(
  parameter int W = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fpa_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]       d_in,
  input  logic               v_in,
  output logic [W-1:0]       d_out,
  output logic               v_out
);
  import fpa_pkg::*;

  logic [W-1:0] data_r;
  logic         valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= v_in;
    end else if (ctl.clr) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= d_in;
    end else if (ctl.clr) begin
      data_r <= '0;
    end
  end

  assign d_out = data_r;
  assign v_out = valid_r;

endmodule
`default_nettype wire

/* sv/first_fit_partition_allocator.sv */
// top level of the first-fit partition allocator
`default_nettype none
// usage: pulse start with in_func, in_process_id and in_request_length while busy is low.
// func 0 allocates, 1 releases the owner's highest entry, 2 loads one free region from
// the region_base and region_length registers (apb, byte addresses 0 and 4).
// each word gives exactly one result, shown for one cycle with out_valid high.
// both tables are rings of cells that, during the ring passes, rotate one entry per cycle
// past a head cell, where the sequencer inspects and rewrites entries.
// steps: init, zero size and unused codes answer from the idle state; allocate ends
// after the first ring pass when it fails, after the second when it succeeds, and then
// passes the drop state when an entry is dropped; release ends after the first pass when
// the owner is absent, after the second on a full table, else after the third and then
// the drop state when two free regions merge. words are taken one at a time: busy stays
// high while a word is in its ring passes, and no new word is accepted until it is done.
// a new word may be started in the cycle its predecessor's result is shown.
// reset empties both tables and loads the register reset values; the receiver
// cannot stall, results are never held.
module first_fit_partition_allocator #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ADDR_BITS     = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_func,
  input  logic [15:0]      in_process_id,
  input  logic [23:0]      in_request_length,
  output logic             out_valid,
  output fpa_pkg::status_t out_status,
  output logic [23:0]      out_block_address,
  output logic [23:0]      out_block_length,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import fpa_pkg::*;
  `include "assert_macros.svh"

  localparam int N  = TABLE_ENTRIES;
  localparam int A  = ADDR_BITS;
  localparam int IW = $clog2(N);
  localparam int FW = 2 * A;
  localparam int UW = 2 * A + 16;

  // config registers
  logic [23:0] base_r, length_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_RESET;
      length_r <= LENGTH_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_IDX_BASE) begin
        base_r <= pwdata[23:0];
      end else begin
        length_r <= pwdata[23:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_IDX_LENGTH) ? {8'd0, length_r} : {8'd0, base_r};

  // cell rings
  logic [FW-1:0] free_d   [N];
  logic          free_v   [N];
  logic [FW-1:0] free_din [N];
  logic          free_vin [N];
  cell_ctl_t     free_ctl [N];
  logic [UW-1:0] used_d   [N];
  logic          used_v   [N];
  logic [UW-1:0] used_din [N];
  logic          used_vin [N];
  cell_ctl_t     used_ctl [N];

  for (genvar g = 0; g < N; g++) begin : g_cells
    fpa_cell #(.W(FW)) u_free (
      .clk(clk), .rst_n(rst_n), .ctl(free_ctl[g]),
      .d_in(free_din[g]), .v_in(free_vin[g]), .d_out(free_d[g]), .v_out(free_v[g])
    );
    fpa_cell #(.W(UW)) u_used (
      .clk(clk), .rst_n(rst_n), .ctl(used_ctl[g]),
      .d_in(used_din[g]), .v_in(used_vin[g]), .d_out(used_d[g]), .v_out(used_v[g])
    );
  end

  // sequencer state
  fpa_state_t state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    func_r, func_nxt;
  logic [15:0]   pid_r, pid_nxt;
  logic [A-1:0]  req_r, req_nxt;
  logic          kf_r, kf_nxt, uf_r, uf_nxt;
  logic [IW-1:0] k_r, k_nxt, u_r, u_nxt;
  logic [A-1:0]  cs_r, cs_nxt, cl_r, cl_nxt;
  logic          upf_r, upf_nxt, upd_r, upd_nxt, lof_r, lof_nxt, slf_r, slf_nxt;
  logic [IW-1:0] up_r, up_nxt, lo_r, lo_nxt, sl_r, sl_nxt, drop_r, drop_nxt;
  logic [A-1:0]  uplen_r, uplen_nxt;
  logic          ov_r, ov_nxt;
  status_t       os_r, os_nxt;
  logic [23:0]   oa_r, oa_nxt, ol_r, ol_nxt;

  logic          rotate, drop, init_ld, last;
  logic [FW-1:0] fb_f;
  logic          fbv_f;
  logic [UW-1:0] fb_u;
  logic          fbv_u;
  logic [A-1:0]  fh_s, fh_l, uh_s, uh_l, be, alloc_addr, ib, il, req_in;
  logic [15:0]   uh_o;
  logic          up_hit, lo_hit;

  assign fh_s       = free_d[0][FW-1:A];
  assign fh_l       = free_d[0][A-1:0];
  assign uh_s       = used_d[0][UW-1:A+16];
  assign uh_l       = used_d[0][A+15:16];
  assign uh_o       = used_d[0][15:0];
  assign be         = cs_r + cl_r;
  assign alloc_addr = cs_r + cl_r - req_r;
  assign ib         = A'(base_r);
  assign il         = A'(length_r);
  assign req_in     = A'(in_request_length);
  assign last       = (cnt_r == IW'(N - 1));
  assign up_hit     = free_v[0] && !upf_r && !upd_r && (fh_s == be);
  assign lo_hit     = free_v[0] && !lof_r && (A'(fh_s + fh_l) == cs_r);

  always_comb begin
    state_nxt = state_r;  cnt_nxt = cnt_r;   func_nxt = func_r; pid_nxt = pid_r;
    req_nxt = req_r;      kf_nxt = kf_r;     uf_nxt = uf_r;     k_nxt = k_r;
    u_nxt = u_r;          cs_nxt = cs_r;     cl_nxt = cl_r;     upf_nxt = upf_r;
    upd_nxt = upd_r;      lof_nxt = lof_r;   slf_nxt = slf_r;   up_nxt = up_r;
    lo_nxt = lo_r;        sl_nxt = sl_r;     drop_nxt = drop_r; uplen_nxt = uplen_r;
    ov_nxt = 1'b0;        os_nxt = os_r;     oa_nxt = oa_r;     ol_nxt = ol_r;
    rotate = 1'b0;        drop = 1'b0;       init_ld = 1'b0;
    fb_f = free_d[0];     fbv_f = free_v[0]; fb_u = used_d[0];  fbv_u = used_v[0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          pid_nxt  = in_process_id;
          req_nxt  = req_in;
          cnt_nxt  = '0;
          kf_nxt = 1'b0; uf_nxt = 1'b0; upf_nxt = 1'b0; upd_nxt = 1'b0;
          lof_nxt = 1'b0; slf_nxt = 1'b0;
          ov_nxt = 1'b1; os_nxt = ST_OK; oa_nxt = '0; ol_nxt = '0;
          case (in_func)
            FN_ALLOC: begin
              if (req_in == '0) begin
                os_nxt = ST_ZERO;
              end else begin
                ov_nxt    = 1'b0;
                state_nxt = S_PASS1;
              end
            end
            FN_FREE: begin
              ov_nxt    = 1'b0;
              state_nxt = S_PASS1;
            end
            FN_INIT: begin
              init_ld = 1'b1;
              if (il != '0) begin
                oa_nxt = 24'(ib);
                ol_nxt = 24'(il);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PASS1: begin
        rotate  = 1'b1;
        cnt_nxt = last ? '0 : cnt_r + 1'b1;
        if (func_r == FN_ALLOC) begin
          if (!kf_r && free_v[0] && fh_l >= req_r) begin
            kf_nxt = 1'b1; k_nxt = cnt_r; cs_nxt = fh_s; cl_nxt = fh_l;
          end
          if (!uf_r && !used_v[0]) begin
            uf_nxt = 1'b1; u_nxt = cnt_r;
          end
          if (last) begin
            if (!kf_nxt || !uf_nxt) begin
              state_nxt = S_IDLE;
              ov_nxt = 1'b1; os_nxt = kf_nxt ? ST_FULL : ST_NOFIT; oa_nxt = '0; ol_nxt = '0;
            end else begin
              state_nxt = S_PASS2;
            end
          end
        end else begin
          if (used_v[0] && uh_o == pid_r && (!uf_r || uh_s > cs_r)) begin
            uf_nxt = 1'b1; u_nxt = cnt_r; cs_nxt = uh_s; cl_nxt = uh_l;
          end
          if (last) begin
            if (!uf_nxt) begin
              state_nxt = S_IDLE;
              ov_nxt = 1'b1; os_nxt = ST_NOPROC; oa_nxt = '0; ol_nxt = '0;
            end else begin
              state_nxt = S_PASS2;
            end
          end
        end
      end
      S_PASS2: begin
        rotate  = 1'b1;
        cnt_nxt = last ? '0 : cnt_r + 1'b1;
        if (func_r == FN_ALLOC) begin
          if (cnt_r == k_r) begin
            fb_f = {fh_s, A'(fh_l - req_r)};
          end
          if (cnt_r == u_r) begin
            fb_u  = {alloc_addr, req_r, pid_r};
            fbv_u = 1'b1;
          end
          if (last) begin
            if (cl_r == req_r) begin
              drop_nxt = k_r; state_nxt = S_DROP;
            end else begin
              state_nxt = S_IDLE;
              ov_nxt = 1'b1; os_nxt = ST_OK;
              oa_nxt = 24'(alloc_addr); ol_nxt = 24'(req_r);
            end
          end
        end else begin
          if (lo_hit) begin
            lof_nxt = 1'b1; lo_nxt = cnt_r;
          end
          if (up_hit && lo_hit) begin
            upd_nxt = 1'b1;
          end else if (up_hit) begin
            upf_nxt = 1'b1; up_nxt = cnt_r; uplen_nxt = fh_l;
          end
          if (!slf_r && !free_v[0]) begin
            slf_nxt = 1'b1; sl_nxt = cnt_r;
          end
          if (last) begin
            if (!upf_nxt && !lof_nxt && !slf_nxt) begin
              state_nxt = S_IDLE;
              ov_nxt = 1'b1; os_nxt = ST_FULL; oa_nxt = '0; ol_nxt = '0;
            end else begin
              state_nxt = S_PASS3;
            end
          end
        end
      end
      S_PASS3: begin
        rotate  = 1'b1;
        cnt_nxt = last ? '0 : cnt_r + 1'b1;
        if (cnt_r == u_r) begin
          fb_u  = '0;
          fbv_u = 1'b0;
        end
        if (lof_r) begin
          if (cnt_r == lo_r) begin
            fb_f = {fh_s, A'(fh_l + cl_r + (upf_r ? uplen_r : '0))};
          end
        end else if (upf_r) begin
          if (cnt_r == up_r) begin
            fb_f = {cs_r, A'(fh_l + cl_r)};
          end
        end else if (cnt_r == sl_r) begin
          fb_f  = {cs_r, cl_r};
          fbv_f = 1'b1;
        end
        if (last) begin
          if (lof_r && upf_r) begin
            drop_nxt = up_r; state_nxt = S_DROP;
          end else begin
            state_nxt = S_IDLE;
            ov_nxt = 1'b1; os_nxt = ST_OK; oa_nxt = 24'(cs_r); ol_nxt = 24'(cl_r);
          end
        end
      end
      S_DROP: begin
        drop      = 1'b1;
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        os_nxt    = ST_OK;
        if (func_r == FN_ALLOC) begin
          oa_nxt = 24'(alloc_addr); ol_nxt = 24'(req_r);
        end else begin
          oa_nxt = 24'(cs_r); ol_nxt = 24'(cl_r);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // neighbor hand-off between cells
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i < N - 1) begin
        free_din[i] = free_d[(i + 1) % N];
        free_vin[i] = free_v[(i + 1) % N];
        used_din[i] = used_d[(i + 1) % N];
        used_vin[i] = used_v[(i + 1) % N];
      end else begin
        free_din[i] = drop ? '0 : fb_f;
        free_vin[i] = drop ? 1'b0 : fbv_f;
        used_din[i] = fb_u;
        used_vin[i] = fbv_u;
      end
      free_ctl[i].clr  = init_ld;
      free_ctl[i].load = rotate || (drop && IW'(i) >= drop_r);
      used_ctl[i].clr  = init_ld;
      used_ctl[i].load = rotate;
    end
    if (init_ld) begin
      free_din[0]      = {ib, il};
      free_vin[0]      = (il != '0);
      free_ctl[0].load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;   func_r <= func_nxt; pid_r <= pid_nxt;   req_r <= req_nxt;
    kf_r <= kf_nxt;     uf_r <= uf_nxt;     k_r <= k_nxt;       u_r <= u_nxt;
    cs_r <= cs_nxt;     cl_r <= cl_nxt;     upf_r <= upf_nxt;   upd_r <= upd_nxt;
    lof_r <= lof_nxt;   slf_r <= slf_nxt;   up_r <= up_nxt;     lo_r <= lo_nxt;
    sl_r <= sl_nxt;     drop_r <= drop_nxt; uplen_r <= uplen_nxt;
    os_r <= os_nxt;     oa_r <= oa_nxt;     ol_r <= ol_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_status        = os_r;
  assign out_block_address = oa_r;
  assign out_block_length  = ol_r;

  logic [N-1:0] fv_vec;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      fv_vec[i] = free_v[i];
    end
  end

  `FPA_ASSERT_SAME(a_free_packed, clk, rst_n, state_r == S_IDLE, (fv_vec & (fv_vec + 1'b1)) == '0)
  `FPA_ASSERT_NEXT(a_word_progress, clk, rst_n, start && !busy, busy || out_valid)
  `FPA_ASSERT_SAME(a_error_zero, clk, rst_n, out_valid && out_status != ST_OK,
                   out_block_address == '0 && out_block_length == '0)

endmodule
`default_nettype wire

/* dv/tb_first_fit_partition_allocator.sv */
// testbench for the first-fit partition allocator: random and directed words checked by a predictor
`default_nettype none
module tb_first_fit_partition_allocator;
  import fpa_pkg::*;

  localparam int N = 16;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] pid;
    logic [23:0] len;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] addr;
    logic [23:0] len;
  } rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = '0;
  logic [15:0] in_process_id = '0;
  logic [23:0] in_request_length = '0;
  logic        out_valid;
  status_t     out_status;
  logic [23:0] out_block_address;
  logic [23:0] out_block_length;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  first_fit_partition_allocator dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor state
  logic [23:0] cfg_base, cfg_len;
  logic [23:0] fr_start [N];
  logic [23:0] fr_len [N];
  logic        fr_ok [N];
  logic [23:0] us_start [N];
  logic [23:0] us_len [N];
  logic [15:0] us_owner [N];
  logic        us_ok [N];

  cmd_t pending_words[$];
  rsp_t expected_rsp[$];
  int   errors = 0;
  int   checked = 0;
  int   ok_allocs = 0;
  int   merges = 0;
  int   send_idle_pct = 0;

  function automatic void clear_tables();
    for (int i = 0; i < N; i++) begin
      fr_start[i] = '0; fr_len[i] = '0; fr_ok[i] = 1'b0;
      us_start[i] = '0; us_len[i] = '0; us_owner[i] = '0; us_ok[i] = 1'b0;
    end
  endfunction

  function automatic int free_entries();
    int n;
    n = 0;
    while (n < N && fr_ok[n]) n++;
    return n;
  endfunction

  function automatic void drop_free(int k);
    for (int i = k; i + 1 < N; i++) begin
      fr_start[i] = fr_start[i+1]; fr_len[i] = fr_len[i+1]; fr_ok[i] = fr_ok[i+1];
    end
    fr_start[N-1] = '0; fr_len[N-1] = '0; fr_ok[N-1] = 1'b0;
  endfunction

  function automatic rsp_t allocate_region(logic [15:0] pid, logic [23:0] req);
    int n, k, u;
    logic [23:0] a;
    n = free_entries(); k = -1; u = -1;
    if (req == 0) return '{ST_ZERO, 24'd0, 24'd0};
    for (int i = 0; i < n; i++)
      if (k < 0 && fr_len[i] >= req) k = i;
    if (k < 0) return '{ST_NOFIT, 24'd0, 24'd0};
    for (int i = 0; i < N; i++)
      if (u < 0 && !us_ok[i]) u = i;
    if (u < 0) return '{ST_FULL, 24'd0, 24'd0};
    a = fr_start[k] + fr_len[k] - req;
    fr_len[k] = fr_len[k] - req;
    us_start[u] = a; us_len[u] = req; us_owner[u] = pid; us_ok[u] = 1'b1;
    if (fr_len[k] == 0) drop_free(k);
    ok_allocs++;
    return '{ST_OK, a, req};
  endfunction

  function automatic rsp_t release_region(logic [15:0] pid);
    int n, u, up, lo;
    logic [23:0] bs, bl, be;
    n = free_entries(); u = -1; up = -1; lo = -1;
    for (int i = 0; i < N; i++)
      if (us_ok[i] && us_owner[i] == pid && (u < 0 || us_start[i] > us_start[u])) u = i;
    if (u < 0) return '{ST_NOPROC, 24'd0, 24'd0};
    bs = us_start[u]; bl = us_len[u]; be = bs + bl;
    for (int i = 0; i < n; i++) begin
      if (up < 0 && fr_start[i] == be) up = i;
      if (lo < 0 && 24'(fr_start[i] + fr_len[i]) == bs) lo = i;
    end
    if (up == lo) up = -1;
    if (up < 0 && lo < 0 && n >= N) return '{ST_FULL, 24'd0, 24'd0};
    us_ok[u] = 1'b0; us_start[u] = '0; us_len[u] = '0; us_owner[u] = '0;
    if (lo >= 0 && up >= 0) begin
      fr_len[lo] = fr_len[lo] + bl + fr_len[up];
      drop_free(up);
      merges++;
    end else if (lo >= 0) begin
      fr_len[lo] = fr_len[lo] + bl;
    end else if (up >= 0) begin
      fr_start[up] = bs;
      fr_len[up] = fr_len[up] + bl;
    end else begin
      fr_start[n] = bs; fr_len[n] = bl; fr_ok[n] = 1'b1;
    end
    return '{ST_OK, bs, bl};
  endfunction

  function automatic rsp_t predict_word(cmd_t c);
    case (c.func)
      FN_ALLOC: return allocate_region(c.pid, c.len);
      FN_FREE:  return release_region(c.pid);
      FN_INIT: begin
        clear_tables();
        if (cfg_len == 0) return '{ST_OK, 24'd0, 24'd0};
        fr_start[0] = cfg_base; fr_len[0] = cfg_len; fr_ok[0] = 1'b1;
        return '{ST_OK, cfg_base, cfg_len};
      end
      default: return '{ST_OK, 24'd0, 24'd0};
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!start || !busy) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_t c;
          c = pending_words.pop_front();
          start <= 1'b1;
          in_func <= c.func;
          in_process_id <= c.pid;
          in_request_length <= c.len;
          expected_rsp.push_back(predict_word(c));
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      rsp_t got, exp_r;
      got = '{out_status, out_block_address, out_block_length};
      checked++;
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_rsp.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp status %0d addr %h len %h, got status %0d addr %h len %h",
                     exp_r.status, exp_r.addr, exp_r.len, got.status, got.addr, got.len);
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [23:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {8'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_IDX_BASE) cfg_base = val;
    else cfg_len = val;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || start || expected_rsp.size() > 0) @(posedge clk);
    repeat (3 * N + 8) @(posedge clk);
  endtask

  function automatic void push(logic [1:0] f, logic [15:0] p, logic [23:0] l);
    pending_words.push_back('{f, p, l});
  endfunction

  function automatic logic [23:0] rand_len(logic [23:0] total);
    case ($urandom_range(9))
      0: return 24'($urandom);
      1: return 24'd0;
      default: return 24'($urandom_range(1, (total / 6) + 1));
    endcase
  endfunction

  task automatic random_phase(int count, int idle);
    send_idle_pct = idle;
    push(FN_INIT, 16'($urandom), 24'($urandom));
    for (int i = 0; i < count; i++) begin
      logic [15:0] p;
      int r;
      r = $urandom_range(99);
      p = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
      if (r < 48) push(FN_ALLOC, p, rand_len(cfg_len));
      else if (r < 94) push(FN_FREE, p, 24'($urandom));
      else if (r < 97) push(FN_UNUSED, p, 24'($urandom));
      else push(FN_INIT, p, 24'($urandom));
    end
    drain();
  endtask

  initial begin
    cfg_base = BASE_RESET;
    cfg_len = LENGTH_RESET;
    clear_tables();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    push(FN_FREE, 16'd5, 24'd0);
    push(FN_ALLOC, 16'd1, 24'd10);
    push(FN_INIT, 16'hffff, 24'hffffff);
    push(FN_ALLOC, 16'd1, 24'd0);
    push(FN_ALLOC, 16'hffff, 24'hffffff);
    push(FN_ALLOC, 16'd1, 24'd100);
    push(FN_ALLOC, 16'd1, 24'd200);
    push(FN_ALLOC, 16'd2, 24'd300);
    push(FN_FREE, 16'd1, 24'd0);
    push(FN_FREE, 16'd2, 24'd0);
    push(FN_FREE, 16'd1, 24'd0);
    push(FN_UNUSED, 16'hffff, 24'hffffff);
    for (int i = 0; i < 17; i++) push(FN_ALLOC, 16'(i), 24'd1);
    drain();
    for (int i = 0; i < 16; i += 2) push(FN_FREE, 16'(i), 24'd0);
    push(FN_FREE, 16'd15, 24'd0);
    drain();

    write_reg(REG_IDX_BASE, 24'hffff00);
    write_reg(REG_IDX_LENGTH, 24'h000200);
    push(FN_INIT, 16'd0, 24'd0);
    push(FN_ALLOC, 16'd3, 24'h000200);
    push(FN_FREE, 16'd3, 24'd0);
    push(FN_ALLOC, 16'd4, 24'h000180);
    drain();
    write_reg(REG_IDX_LENGTH, 24'd0);
    push(FN_INIT, 16'd0, 24'd0);
    push(FN_ALLOC, 16'd1, 24'd1);
    drain();

    write_reg(REG_IDX_BASE, 24'd0);
    write_reg(REG_IDX_LENGTH, 24'hffffff);
    random_phase(420, 0);
    write_reg(REG_IDX_BASE, 24'($urandom));
    write_reg(REG_IDX_LENGTH, 24'($urandom_range(1, 4000)));
    random_phase(420, 67);
    write_reg(REG_IDX_BASE, 24'h123456);
    write_reg(REG_IDX_LENGTH, 24'd64);
    random_phase(420, 33);
    write_reg(REG_IDX_BASE, 24'($urandom));
    write_reg(REG_IDX_LENGTH, 24'd1);
    random_phase(60, 0);
    write_reg(REG_IDX_BASE, BASE_RESET);
    write_reg(REG_IDX_LENGTH, LENGTH_RESET);
    random_phase(380, 50);

    $display("checked %0d results, %0d successful allocations, %0d double merges",
             checked, ok_allocs, merges);
    if (errors == 0 && expected_rsp.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
